@@ rtl/lcdseq_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and constants of the character display write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int unsigned TICK16_W  = 16;
  localparam int unsigned HOLD_W    = 20;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [TICK16_W-1:0] PULSE_RESET   = 16'd10;
  localparam logic [TICK16_W-1:0] SETTLE_RESET  = 16'd300;
  localparam logic [HOLD_W-1:0]   POWERUP_RESET = 20'd300000;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_PULSE   = 2'd0;
  localparam logic [1:0] REG_SETTLE  = 2'd1;
  localparam logic [1:0] REG_POWERUP = 2'd2;

  // raw nibble strobed once at the start of initialization
  localparam logic [3:0] WAKE_NIBBLE = 4'h2;
  // set-address command base
  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [1:0] INIT_LAST   = 2'd3;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_CURSOR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    BUS_KEEP = 2'd0,
    BUS_HI   = 2'd1,
    BUS_LO   = 2'd2,
    BUS_WAKE = 2'd3
  } bus_sel_t;

  typedef enum logic [1:0] {
    HOLD_ZERO    = 2'd0,
    HOLD_PULSE   = 2'd1,
    HOLD_SETTLE  = 2'd2,
    HOLD_POWERUP = 2'd3
  } hold_sel_t;

  typedef struct packed {
    logic [TICK16_W-1:0] pulse;
    logic [TICK16_W-1:0] settle;
    logic [HOLD_W-1:0]   powerup;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic      emit;
    logic      rs_set;
    logic      rs_val;
    logic      en_set;
    logic      en_val;
    bus_sel_t  bus_sel;
    hold_sel_t hold_sel;
    logic      last;
    logic      byte_load;
    logic      byte_from_init;
    logic [1:0] init_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
  } dp_status_t;

  // command bytes of the initialization sequence
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h2C;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/lcdseq_if.sv @@
// ----------------------------------------------------------------------------
// lcdseq interfaces
// Valid/ready channels for action items and pin-state results.
// ----------------------------------------------------------------------------
interface lcdseq_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_value;
  logic [6:0] column;
  logic [2:0] row;

  modport source (output valid, action, byte_value, column, row, input ready);
  modport sink   (input valid, action, byte_value, column, row, output ready);
endinterface

interface lcdseq_result_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable;
  logic [3:0]  data_nibble;
  logic [19:0] hold_ticks;
  logic        last;

  modport source (output valid, reg_select, enable, data_nibble, hold_ticks, last,
                  input ready);
  modport sink   (input valid, reg_select, enable, data_nibble, hold_ticks, last,
                  output ready);
endinterface

@@ rtl/lcdseq_cfg.sv @@
// ----------------------------------------------------------------------------
// lcdseq_cfg
// APB register file holding the pulse, settle and power-up tick counts.
// ----------------------------------------------------------------------------
module lcdseq_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lcdseq_pkg::PADDR_W-1:0]     paddr,
  input  logic [lcdseq_pkg::PDATA_W-1:0]     pwdata,
  output logic [lcdseq_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready,
  output lcdseq_pkg::cfg_t                   cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse   <= lcdseq_pkg::PULSE_RESET;
      cfg.settle  <= lcdseq_pkg::SETTLE_RESET;
      cfg.powerup <= lcdseq_pkg::POWERUP_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        lcdseq_pkg::REG_PULSE:   cfg.pulse   <= pwdata[lcdseq_pkg::TICK16_W-1:0];
        lcdseq_pkg::REG_SETTLE:  cfg.settle  <= pwdata[lcdseq_pkg::TICK16_W-1:0];
        lcdseq_pkg::REG_POWERUP: cfg.powerup <= pwdata[lcdseq_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lcdseq_pkg::REG_PULSE:
        prdata = {{(lcdseq_pkg::PDATA_W-lcdseq_pkg::TICK16_W){1'b0}}, cfg.pulse};
      lcdseq_pkg::REG_SETTLE:
        prdata = {{(lcdseq_pkg::PDATA_W-lcdseq_pkg::TICK16_W){1'b0}}, cfg.settle};
      lcdseq_pkg::REG_POWERUP:
        prdata = {{(lcdseq_pkg::PDATA_W-lcdseq_pkg::HOLD_W){1'b0}}, cfg.powerup};
      default:
        prdata = '0;
    endcase
  end

endmodule

@@ rtl/lcdseq_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencer state machine: walks the pin-state steps of each action.
// ----------------------------------------------------------------------------
module lcdseq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  lcdseq_pkg::action_t     in_action,
  output logic                    in_ready,
  input  lcdseq_pkg::dp_status_t  status,
  output lcdseq_pkg::dp_cmd_t     cmd
);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_PWR     = 14'b00000000000010,
    ST_I_RS    = 14'b00000000000100,
    ST_I_EN    = 14'b00000000001000,
    ST_I_BUS   = 14'b00000000010000,
    ST_I_SET   = 14'b00000000100000,
    ST_B_RS    = 14'b00000001000000,
    ST_B_HI    = 14'b00000010000000,
    ST_B_HIEN  = 14'b00000100000000,
    ST_B_HIOFF = 14'b00001000000000,
    ST_B_LO    = 14'b00010000000000,
    ST_B_LOEN  = 14'b00100000000000,
    ST_B_END   = 14'b01000000000000,
    ST_B_RSOFF = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic       is_data, is_data_next;
  logic       in_init, in_init_next;
  logic [1:0] init_idx, init_idx_next;
  logic       go;

  assign go = status.slot_free;

  always_comb begin
    state_next    = state;
    is_data_next  = is_data;
    in_init_next  = in_init;
    init_idx_next = init_idx;
    in_ready      = 1'b0;

    cmd                = '0;
    cmd.bus_sel        = lcdseq_pkg::BUS_KEEP;
    cmd.hold_sel       = lcdseq_pkg::HOLD_ZERO;
    cmd.init_idx       = init_idx;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_load = 1'b1;
          is_data_next  = (in_action == lcdseq_pkg::ACT_DATA);
          in_init_next  = (in_action == lcdseq_pkg::ACT_INIT);
          init_idx_next = '0;
          state_next    = (in_action == lcdseq_pkg::ACT_INIT) ? ST_PWR : ST_B_RS;
        end
      end
      ST_PWR: begin
        cmd.emit     = go;
        cmd.hold_sel = lcdseq_pkg::HOLD_POWERUP;
        if (go) state_next = ST_I_RS;
      end
      ST_I_RS: begin
        cmd.emit   = go;
        cmd.rs_set = 1'b1;
        if (go) state_next = ST_I_EN;
      end
      ST_I_EN: begin
        cmd.emit   = go;
        cmd.en_set = 1'b1;
        cmd.en_val = 1'b1;
        if (go) state_next = ST_I_BUS;
      end
      ST_I_BUS: begin
        cmd.emit    = go;
        cmd.bus_sel = lcdseq_pkg::BUS_WAKE;
        if (go) state_next = ST_I_SET;
      end
      ST_I_SET: begin
        cmd.emit           = go;
        cmd.en_set         = 1'b1;
        cmd.hold_sel       = lcdseq_pkg::HOLD_SETTLE;
        // fetch the first init command byte
        cmd.byte_load      = go;
        cmd.byte_from_init = 1'b1;
        cmd.init_idx       = '0;
        if (go) state_next = ST_B_RS;
      end
      ST_B_RS: begin
        cmd.emit   = go;
        cmd.rs_set = 1'b1;
        cmd.rs_val = is_data;
        if (go) state_next = ST_B_HI;
      end
      ST_B_HI: begin
        cmd.emit    = go;
        cmd.bus_sel = lcdseq_pkg::BUS_HI;
        if (go) state_next = ST_B_HIEN;
      end
      ST_B_HIEN: begin
        cmd.emit     = go;
        cmd.en_set   = 1'b1;
        cmd.en_val   = 1'b1;
        cmd.hold_sel = lcdseq_pkg::HOLD_PULSE;
        if (go) state_next = ST_B_HIOFF;
      end
      ST_B_HIOFF: begin
        cmd.emit   = go;
        cmd.en_set = 1'b1;
        if (go) state_next = ST_B_LO;
      end
      ST_B_LO: begin
        cmd.emit    = go;
        cmd.bus_sel = lcdseq_pkg::BUS_LO;
        if (go) state_next = ST_B_LOEN;
      end
      ST_B_LOEN: begin
        cmd.emit     = go;
        cmd.en_set   = 1'b1;
        cmd.en_val   = 1'b1;
        cmd.hold_sel = lcdseq_pkg::HOLD_PULSE;
        if (go) state_next = ST_B_END;
      end
      ST_B_END: begin
        cmd.emit     = go;
        cmd.en_set   = 1'b1;
        cmd.hold_sel = is_data ? lcdseq_pkg::HOLD_ZERO : lcdseq_pkg::HOLD_SETTLE;
        cmd.last     = ~is_data & (~in_init | (init_idx == lcdseq_pkg::INIT_LAST));
        if (go) begin
          if (is_data) begin
            state_next = ST_B_RSOFF;
          end else if (in_init && init_idx != lcdseq_pkg::INIT_LAST) begin
            cmd.byte_load      = 1'b1;
            cmd.byte_from_init = 1'b1;
            cmd.init_idx       = init_idx + 2'd1;
            init_idx_next      = init_idx + 2'd1;
            state_next         = ST_B_RS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_B_RSOFF: begin
        cmd.emit     = go;
        cmd.rs_set   = 1'b1;
        cmd.hold_sel = lcdseq_pkg::HOLD_SETTLE;
        cmd.last     = 1'b1;
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      is_data  <= 1'b0;
      in_init  <= 1'b0;
      init_idx <= '0;
    end else begin
      state    <= state_next;
      is_data  <= is_data_next;
      in_init  <= in_init_next;
      init_idx <= init_idx_next;
    end
  end

endmodule

@@ rtl/lcdseq_dp.sv @@
// ----------------------------------------------------------------------------
// lcdseq_dp
// Pin-level registers, byte register and the result output register.
// ----------------------------------------------------------------------------
module lcdseq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  lcdseq_pkg::cfg_t                    cfg,
  input  lcdseq_pkg::action_t                 in_action,
  input  logic [7:0]                          in_byte_value,
  input  logic [6:0]                          in_column,
  input  logic [2:0]                          in_row,
  input  lcdseq_pkg::dp_cmd_t                 cmd,
  output lcdseq_pkg::dp_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_reg_select,
  output logic                                out_enable,
  output logic [3:0]                          out_data_nibble,
  output logic [lcdseq_pkg::HOLD_W-1:0]       out_hold_ticks,
  output logic                                out_last
);

  logic       rs_level, enable_level;
  logic [3:0] bus_nibble;
  logic [7:0] byte_reg;

  logic       rs_next, en_next;
  logic [3:0] bus_next;
  logic [7:0] cursor_addr, in_byte, byte_next;
  logic [1:0] row_off;
  logic [lcdseq_pkg::HOLD_W-1:0] hold;

  // address wraps modulo 256, so only row bits [1:0] matter
  assign row_off     = in_row[1:0] - 2'd1;
  assign cursor_addr = lcdseq_pkg::CURSOR_BASE + {row_off, 6'd0} + {1'b0, in_column} - 8'd1;
  assign in_byte     = (in_action == lcdseq_pkg::ACT_CURSOR) ? cursor_addr : in_byte_value;
  assign byte_next   = cmd.byte_from_init ? lcdseq_pkg::init_cmd(cmd.init_idx) : in_byte;

  assign rs_next = cmd.rs_set ? cmd.rs_val : rs_level;
  assign en_next = cmd.en_set ? cmd.en_val : enable_level;

  always_comb begin
    case (cmd.bus_sel)
      lcdseq_pkg::BUS_HI:   bus_next = byte_reg[7:4];
      lcdseq_pkg::BUS_LO:   bus_next = byte_reg[3:0];
      lcdseq_pkg::BUS_WAKE: bus_next = lcdseq_pkg::WAKE_NIBBLE;
      default:              bus_next = bus_nibble;
    endcase
  end

  always_comb begin
    case (cmd.hold_sel)
      lcdseq_pkg::HOLD_PULSE:
        hold = {{(lcdseq_pkg::HOLD_W-lcdseq_pkg::TICK16_W){1'b0}}, cfg.pulse};
      lcdseq_pkg::HOLD_SETTLE:
        hold = {{(lcdseq_pkg::HOLD_W-lcdseq_pkg::TICK16_W){1'b0}}, cfg.settle};
      lcdseq_pkg::HOLD_POWERUP:
        hold = cfg.powerup;
      default:
        hold = '0;
    endcase
  end

  assign status.slot_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_level     <= 1'b0;
      enable_level <= 1'b0;
      bus_nibble   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.emit) begin
        rs_level     <= rs_next;
        enable_level <= en_next;
        bus_nibble   <= bus_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_load) begin
      byte_reg <= byte_next;
    end
    if (cmd.emit) begin
      out_reg_select  <= rs_next;
      out_enable      <= en_next;
      out_data_nibble <= bus_next;
      out_hold_ticks  <= hold;
      out_last        <= cmd.last;
    end
  end

endmodule

@@ rtl/char_lcd_nibble_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns display actions into timed pin states for a 4-bit character display.
// ----------------------------------------------------------------------------
// Each accepted item is one action (initialize, write command, write data,
// set cursor) and comes back as a stream of pin states on the result channel,
// one transfer per state, each carrying register select, enable, the D7..D4
// nibble and the number of ticks that state must be held; the final state of
// an action has last set. The block works on one action at a time: after the
// accept cycle the controller emits one pin state per cycle through a single
// output register as long as the sink takes every transfer; a stall on the
// result side holds the controller in its current step. A new action is
// accepted as soon as the controller is back at rest, even while the last pin
// state still waits to be taken. Tick counts come from the APB registers at
// 0x0 (enable pulse), 0x4 (settle after each byte) and 0x8 (power-up wait);
// write them only while no action is in flight.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  lcdseq_item_if.sink                      item,
  lcdseq_result_if.source                  result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcdseq_pkg::PADDR_W-1:0]   paddr,
  input  logic [lcdseq_pkg::PDATA_W-1:0]   pwdata,
  output logic [lcdseq_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready
);

  lcdseq_pkg::cfg_t       cfg;
  lcdseq_pkg::dp_cmd_t    cmd;
  lcdseq_pkg::dp_status_t status;
  lcdseq_pkg::action_t    action;

  assign action = lcdseq_pkg::action_t'(item.action);

  // tick registers
  lcdseq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step sequencer, owns the input handshake
  lcdseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_action (action),
    .in_ready  (item.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // pin registers and output register, owns the result handshake
  lcdseq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_action       (action),
    .in_byte_value   (item.byte_value),
    .in_column       (item.column),
    .in_row          (item.row),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_reg_select  (result.reg_select),
    .out_enable      (result.enable),
    .out_data_nibble (result.data_nibble),
    .out_hold_ticks  (result.hold_ticks),
    .out_last        (result.last)
  );

endmodule

@@ rtl/lcdseq_checker.sv @@
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level assertions for the display write sequencer, bound to the top.
// ----------------------------------------------------------------------------
module lcdseq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_reg_select,
  input logic        out_enable,
  input logic [3:0]  out_data_nibble,
  input logic [19:0] out_hold_ticks,
  input logic        out_last
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_reg_select) &&
      $stable(out_enable) && $stable(out_data_nibble) &&
      $stable(out_hold_ticks) && $stable(out_last))
    else $error("result changed while stalled");

  // one action in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an action is in flight");

  // every action ends with enable and register select low
  a_last_idle_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> !out_enable && !out_reg_select)
    else $error("action ended with enable or register select high");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_lcdseq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (item.valid),
  .in_ready        (item.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_reg_select  (result.reg_select),
  .out_enable      (result.enable),
  .out_data_nibble (result.data_nibble),
  .out_hold_ticks  (result.hold_ticks),
  .out_last        (result.last)
);
